[design/cfq_pkg.sv]
`default_nettype none

package cfq_pkg;

    // fixed field widths
    localparam int CAP_W  = 11;
    localparam int VAL_W  = 32;
    localparam int KIND_W = 2;

    // operation codes; any other code is a status query
    localparam logic [KIND_W-1:0] KIND_ENQ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic update;   // perform operation of accepted request
        logic read;     // read front/rear entries
        logic load;     // load result register
    } cmd_t;

endpackage

`default_nettype wire

[design/cfq_ctrl.sv]
`default_nettype none

module cfq_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire              m_ready,
    output cfq_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.update = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // wait for result register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_accept_to_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_READ))
        else $error("accepted request did not move to read");

    a_read_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_LOAD))
        else $error("read state did not move to load");

endmodule

`default_nettype wire

[design/cfq_datapath.sv]
`default_nettype none

module cfq_datapath #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  cfq_pkg::cmd_t                      cmd,
    input  wire                                cfg_wr_en,
    input  wire        [cfq_pkg::CAP_W-1:0]    cfg_wr_data,
    input  wire        [cfq_pkg::KIND_W-1:0]   s_kind,
    input  wire signed [cfq_pkg::VAL_W-1:0]    s_enq_value,
    output logic                               m_accepted,
    output logic signed [cfq_pkg::VAL_W-1:0]   m_front_value,
    output logic signed [cfq_pkg::VAL_W-1:0]   m_rear_value,
    output logic                               m_empty_flag,
    output logic                               m_full_flag,
    output logic       [cfq_pkg::CAP_W-1:0]    m_occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = ((AW > cfq_pkg::CAP_W) ? AW : cfq_pkg::CAP_W) + 1;
    localparam logic [CW-1:0] DEPTH_W = CW'(DEPTH);
    localparam logic [cfq_pkg::CAP_W-1:0] CAP_MAX =
        (DEPTH < 2047) ? cfq_pkg::CAP_W'(DEPTH) : {cfq_pkg::CAP_W{1'b1}};
    localparam logic [cfq_pkg::CAP_W-1:0] CAP_RESET =
        (DEPTH < 1024) ? cfq_pkg::CAP_W'(DEPTH) : cfq_pkg::CAP_W'(1024);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [cfq_pkg::CAP_W-1:0] capacity_reg, capacity_next;
    logic [cfq_pkg::CAP_W-1:0] count_reg, count_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [AW-1:0]             tail_reg, tail_next;
    logic                      accepted_reg, accepted_next;
    logic [DATA_WIDTH-1:0]     front_rd_reg, rear_rd_reg;
    logic [AW-1:0]             rear_addr;
    logic [cfq_pkg::CAP_W-1:0] cfg_clamped;
    logic                      is_enq, is_deq, enq_ok, deq_ok, wr_en;

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] ptr,
                                                input logic [cfq_pkg::CAP_W-1:0] cap);
        logic [CW-1:0] n;
        n = CW'(ptr) + CW'(1);
        return (n >= CW'(cap)) ? '0 : AW'(n);
    endfunction

    always_comb begin
        cfg_clamped = cfg_wr_data;
        if (cfg_wr_data == '0) begin
            cfg_clamped = cfq_pkg::CAP_W'(1);
        end else if (CW'(cfg_wr_data) > DEPTH_W) begin
            cfg_clamped = CAP_MAX;
        end
    end

    assign is_enq = (s_kind == cfq_pkg::KIND_ENQ);
    assign is_deq = (s_kind == cfq_pkg::KIND_DEQ);
    assign enq_ok = (count_reg < capacity_reg);
    assign deq_ok = (count_reg != '0);
    assign wr_en  = cmd.update && is_enq && enq_ok;

    always_comb begin
        capacity_next = capacity_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        accepted_next = accepted_reg;
        if (cfg_wr_en) begin
            // new capacity empties the queue
            capacity_next = cfg_clamped;
            count_next    = '0;
            head_next     = '0;
            tail_next     = '0;
        end else if (cmd.update) begin
            accepted_next = 1'b1;
            if (is_enq) begin
                accepted_next = enq_ok;
                if (enq_ok) begin
                    tail_next  = wrap_next(tail_reg, capacity_reg);
                    count_next = count_reg + cfq_pkg::CAP_W'(1);
                end
            end else if (is_deq) begin
                accepted_next = deq_ok;
                if (deq_ok) begin
                    head_next  = wrap_next(head_reg, capacity_reg);
                    count_next = count_reg - cfq_pkg::CAP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
            count_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            accepted_reg <= 1'b0;
        end else begin
            capacity_reg <= capacity_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            accepted_reg <= accepted_next;
        end
    end

    // entry behind the tail, wrapping at capacity
    assign rear_addr = (tail_reg == '0) ? AW'(capacity_reg - cfq_pkg::CAP_W'(1))
                                        : (tail_reg - AW'(1));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tail_reg] <= DATA_WIDTH'($unsigned(s_enq_value));
        end
        if (cmd.read) begin
            front_rd_reg <= mem[head_reg];
            rear_rd_reg  <= mem[rear_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_accepted    <= accepted_reg;
            m_empty_flag  <= (count_reg == '0);
            m_full_flag   <= (count_reg == capacity_reg);
            m_occupancy   <= count_reg;
            if (count_reg == '0) begin
                m_front_value <= '1;
                m_rear_value  <= '1;
            end else begin
                m_front_value <= $signed(cfq_pkg::VAL_W'(front_rd_reg));
                m_rear_value  <= $signed(cfq_pkg::VAL_W'(rear_rd_reg));
            end
        end
    end

    a_count_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= capacity_reg)
        else $error("entry count above capacity");

    a_ptrs_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (CW'(head_reg) < CW'(capacity_reg)) && (CW'(tail_reg) < CW'(capacity_reg)))
        else $error("pointer beyond capacity");

    a_cap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (capacity_reg != '0) && (CW'(capacity_reg) <= DEPTH_W))
        else $error("capacity out of range");

endmodule

`default_nettype wire

[design/circular_fifo_queue.sv]
`default_nettype none

// Ring-buffer FIFO of signed values with a programmable capacity. Each request
// is an enqueue (kind 0), a dequeue (kind 1) or a status query (kind 2 or 3)
// and yields exactly one result: whether the operation succeeded, the front and
// rear entries (all ones when empty), empty/full flags and occupancy, all taken
// after the operation. Steps per request: pointer update and storage write
// at the accepting edge, a registered two-port storage read of head and rear
// entries, then the result register load, held until an earlier result is
// taken. No new request is taken until the result is loaded; the next one is
// taken while that result still waits on m_ready. Writing capacity (0 taken as
// 1, above DEPTH taken as DEPTH) empties the queue; write it only while the
// block is idle. Storage is not cleared at reset and needs no clearing pass.

module circular_fifo_queue #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // configuration
    input  wire                                cfg_wr_en,
    input  wire        [cfq_pkg::CAP_W-1:0]    cfg_wr_data,
    // request channel
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire        [cfq_pkg::KIND_W-1:0]   s_kind,
    input  wire signed [cfq_pkg::VAL_W-1:0]    s_enq_value,
    // result channel
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic                               m_accepted,
    output logic signed [cfq_pkg::VAL_W-1:0]   m_front_value,
    output logic signed [cfq_pkg::VAL_W-1:0]   m_rear_value,
    output logic                               m_empty_flag,
    output logic                               m_full_flag,
    output logic       [cfq_pkg::CAP_W-1:0]    m_occupancy
);

    cfq_pkg::cmd_t cmd;

    // sequencer: accept, read, load
    cfq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // pointers, count, capacity, storage and result register
    cfq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_kind        (s_kind),
        .s_enq_value   (s_enq_value),
        .m_accepted    (m_accepted),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value),
        .m_empty_flag  (m_empty_flag),
        .m_full_flag   (m_full_flag),
        .m_occupancy   (m_occupancy)
    );

endmodule

`default_nettype wire
